// ===== hw/rtl/ofi_pkg.sv =====
`timescale 1ns / 1ps

package ofi_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int TIME_BITS     = 48;

  localparam int IDX_W   = $clog2(HISTORY_DEPTH);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
  localparam int PRICE_W = 32;
  localparam int TERM_W  = 34;
  localparam int SUM_W   = 41;
  localparam int WIN_W   = 24;
  localparam int CMP_W   = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(5000);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified quote on its way from the front end to the window engine.
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic [TIME_BITS-1:0]     stamp;
    logic                     primed;
  } work_t;

  // One history ring entry.
  typedef struct packed {
    logic signed [TERM_W-1:0] term;
    logic [TIME_BITS-1:0]     stamp;
  } hist_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DROP,
    BK_PUSH,
    BK_EV_RD,
    BK_EV_CHK,
    BK_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/ofi_front.sv =====
`timescale 1ns / 1ps

module ofi_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_bid_price,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_ask_price,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_bid_volume,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_ask_volume,
  input  logic [ofi_pkg::TIME_BITS-1:0]           in_tick_time,
  output logic                                    push_valid,
  input  logic                                    push_ready,
  output ofi_pkg::work_t                          push_work
);

  localparam int EXT_W = ofi_pkg::TERM_W - ofi_pkg::PRICE_W;

  logic [ofi_pkg::PRICE_W-1:0] last_bp_r, last_ap_r, last_bv_r, last_av_r;
  logic                        accept;
  logic                        primed;
  logic signed [ofi_pkg::TERM_W-1:0] bv_s, av_s, lbv_s, lav_s;
  logic signed [ofi_pkg::TERM_W-1:0] e_bid, e_ask;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  // A term needs both stored prices present; otherwise the word only primes.
  assign primed = (last_bp_r != '0) && (last_ap_r != '0);

  assign bv_s  = $signed({{EXT_W{1'b0}}, in_bid_volume});
  assign av_s  = $signed({{EXT_W{1'b0}}, in_ask_volume});
  assign lbv_s = $signed({{EXT_W{1'b0}}, last_bv_r});
  assign lav_s = $signed({{EXT_W{1'b0}}, last_av_r});

  always_comb begin
    if (in_bid_price > last_bp_r) begin
      e_bid = bv_s;
    end else if (in_bid_price < last_bp_r) begin
      e_bid = -lbv_s;
    end else begin
      e_bid = bv_s - lbv_s;
    end
    if (in_ask_price > last_ap_r) begin
      e_ask = -lav_s;
    end else if (in_ask_price < last_ap_r) begin
      e_ask = av_s;
    end else begin
      e_ask = lav_s - av_s;
    end
  end

  always_comb begin
    push_work.term   = primed ? (e_bid - e_ask) : '0;
    push_work.stamp  = in_tick_time;
    push_work.primed = primed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bp_r <= '0;
      last_ap_r <= '0;
      last_bv_r <= '0;
      last_av_r <= '0;
    end else if (accept) begin
      last_bp_r <= in_bid_price;
      last_ap_r <= in_ask_price;
      last_bv_r <= in_bid_volume;
      last_av_r <= in_ask_volume;
    end
  end

endmodule

// ===== hw/rtl/ofi_queue.sv =====
`timescale 1ns / 1ps

module ofi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ofi_pkg::work_t push_work,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ofi_pkg::work_t pop_work
);

  ofi_pkg::work_t                slot_r [ofi_pkg::QUEUE_DEPTH];
  logic [ofi_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ofi_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ofi_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign push_ready = (cnt_r != ofi_pkg::QCNT_W'(ofi_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_work   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ofi_pkg::QPTR_W'(ofi_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ofi_pkg::QPTR_W'(ofi_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_work;
    end
  end

endmodule

// ===== hw/rtl/ofi_back.sv =====
`timescale 1ns / 1ps

module ofi_back (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    pop_valid,
  output logic                                    pop_ready,
  input  ofi_pkg::work_t                          pop_work,
  input  logic [ofi_pkg::WIN_W-1:0]               window_length,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ofi_pkg::TERM_W-1:0]       out_tick_imbalance,
  output logic signed [ofi_pkg::SUM_W-1:0]        out_window_sum,
  output logic [ofi_pkg::CNT_W-1:0]               out_entry_count,
  output logic                                    out_primed
);

  localparam int SEXT_W = ofi_pkg::SUM_W - ofi_pkg::TERM_W;

  ofi_pkg::back_state_t state_r, state_nxt;
  logic signed [ofi_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [ofi_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [ofi_pkg::IDX_W-1:0]        oldest_r, oldest_nxt, oldest_inc;
  ofi_pkg::work_t                   cur_r, cur_nxt;
  logic [ofi_pkg::TIME_BITS-1:0]    cutoff_r, cutoff_nxt;
  logic [ofi_pkg::CMP_W-1:0]        t_ext, w_ext, diff;

  ofi_pkg::hist_t                   ring [ofi_pkg::HISTORY_DEPTH];
  ofi_pkg::hist_t                   rd_r;
  ofi_pkg::hist_t                   wr_data;
  logic                             mem_we, mem_re;
  logic [ofi_pkg::IDX_W:0]          wr_sum;
  logic [ofi_pkg::IDX_W-1:0]        wr_addr;

  logic                             out_valid_r, out_valid_nxt, load_out;
  logic signed [ofi_pkg::TERM_W-1:0] out_term_r;
  logic signed [ofi_pkg::SUM_W-1:0]  out_sum_r;
  logic [ofi_pkg::CNT_W-1:0]         out_count_r;
  logic                              out_primed_r;

  assign out_valid          = out_valid_r;
  assign out_tick_imbalance = out_term_r;
  assign out_window_sum     = out_sum_r;
  assign out_entry_count    = out_count_r;
  assign out_primed         = out_primed_r;

  assign oldest_inc = (oldest_r == ofi_pkg::IDX_W'(ofi_pkg::HISTORY_DEPTH - 1)) ?
                      '0 : oldest_r + 1'b1;

  // Free slot behind the newest entry, wrapped around the ring.
  assign wr_sum  = (ofi_pkg::IDX_W+1)'(oldest_r) + (ofi_pkg::IDX_W+1)'(count_r);
  assign wr_addr = (wr_sum >= (ofi_pkg::IDX_W+1)'(ofi_pkg::HISTORY_DEPTH)) ?
                   ofi_pkg::IDX_W'(wr_sum - (ofi_pkg::IDX_W+1)'(ofi_pkg::HISTORY_DEPTH)) :
                   wr_sum[ofi_pkg::IDX_W-1:0];

  assign wr_data.term  = cur_r.term;
  assign wr_data.stamp = cur_r.stamp;

  // Eviction cutoff floors at zero when the window reaches before time zero.
  assign t_ext = ofi_pkg::CMP_W'(pop_work.stamp);
  assign w_ext = ofi_pkg::CMP_W'(window_length);
  assign diff  = t_ext - w_ext;

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    oldest_nxt = oldest_r;
    cur_nxt    = cur_r;
    cutoff_nxt = cutoff_r;
    pop_ready  = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    load_out   = 1'b0;
    case (state_r)
      ofi_pkg::BK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          cur_nxt    = pop_work;
          cutoff_nxt = (t_ext >= w_ext) ? diff[ofi_pkg::TIME_BITS-1:0] : '0;
          if (!pop_work.primed) begin
            state_nxt = ofi_pkg::BK_DONE;
          end else if (count_r == ofi_pkg::CNT_W'(ofi_pkg::HISTORY_DEPTH)) begin
            mem_re    = 1'b1;
            state_nxt = ofi_pkg::BK_DROP;
          end else begin
            state_nxt = ofi_pkg::BK_PUSH;
          end
        end
      end
      ofi_pkg::BK_DROP: begin
        // Full ring: the oldest entry gives way to the new one.
        sum_nxt    = sum_r - $signed({{SEXT_W{rd_r.term[ofi_pkg::TERM_W-1]}}, rd_r.term});
        oldest_nxt = oldest_inc;
        count_nxt  = count_r - 1'b1;
        state_nxt  = ofi_pkg::BK_PUSH;
      end
      ofi_pkg::BK_PUSH: begin
        mem_we    = 1'b1;
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + $signed({{SEXT_W{cur_r.term[ofi_pkg::TERM_W-1]}}, cur_r.term});
        state_nxt = ofi_pkg::BK_EV_RD;
      end
      ofi_pkg::BK_EV_RD: begin
        if (count_r == '0) begin
          state_nxt = ofi_pkg::BK_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ofi_pkg::BK_EV_CHK;
        end
      end
      ofi_pkg::BK_EV_CHK: begin
        // Only the front entry is tested; eviction stops at the first young one.
        if (rd_r.stamp < cutoff_r) begin
          sum_nxt    = sum_r - $signed({{SEXT_W{rd_r.term[ofi_pkg::TERM_W-1]}}, rd_r.term});
          oldest_nxt = oldest_inc;
          count_nxt  = count_r - 1'b1;
          state_nxt  = ofi_pkg::BK_EV_RD;
        end else begin
          state_nxt = ofi_pkg::BK_DONE;
        end
      end
      ofi_pkg::BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ofi_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = ofi_pkg::BK_IDLE;
      end
    endcase
    out_valid_nxt = load_out | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ofi_pkg::BK_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    cutoff_r <= cutoff_nxt;
    if (load_out) begin
      out_term_r   <= cur_r.term;
      out_sum_r    <= sum_r;
      out_count_r  <= count_r;
      out_primed_r <= cur_r.primed;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_r <= ring[oldest_r];
    end
  end

endmodule

// ===== hw/rtl/order_flow_imbalance_window_unit.sv =====
`timescale 1ns / 1ps

// Order-flow imbalance over a rolling time window.
// Input channel (in_valid/in_ready): one top-of-book quote word per transfer,
// with bid/ask price, bid/ask volume and a nondecreasing tick_time.
// Output channel (out_valid/out_ready): one result word per quote with the
// quote's imbalance term, the windowed sum, the entry count and a primed flag.
// cfg_we/cfg_wdata write the window length; write it only while idle.
// The front end classifies each quote in the accepting cycle and hands it to
// a two-word queue. The window engine then takes a quote (IDLE); a priming
// quote goes straight to the output stage (DONE). A primed one drops the
// oldest entry of a full ring (DROP), is pushed (PUSH), and then the ring
// front is tested entry by entry, each with a memory read (EV_RD) and a
// compare (EV_CHK), before the result is loaded into the output register
// (DONE). The engine takes no new quote until that load; meanwhile the queue
// holds up to two quotes.
// Reset clears the stored quote, the sum and the ring pointers and sets the
// window length to 5000; the ring memory itself is not cleared.
// When the receiver stalls, the output register holds its word, the engine
// waits with the next result, and the queue fills before in_ready drops.
module order_flow_imbalance_window_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [ofi_pkg::WIN_W-1:0]               cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_bid_price,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_ask_price,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_bid_volume,
  input  logic [ofi_pkg::PRICE_W-1:0]             in_ask_volume,
  input  logic [ofi_pkg::TIME_BITS-1:0]           in_tick_time,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ofi_pkg::TERM_W-1:0]       out_tick_imbalance,
  output logic signed [ofi_pkg::SUM_W-1:0]        out_window_sum,
  output logic [ofi_pkg::CNT_W-1:0]               out_entry_count,
  output logic                                    out_primed
);

  logic [ofi_pkg::WIN_W-1:0] window_length_r;
  logic                      push_valid, push_ready, pop_valid, pop_ready;
  ofi_pkg::work_t            push_work, pop_work;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= ofi_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window_length_r <= cfg_wdata;
    end
  end

  ofi_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_bid_price  (in_bid_price),
    .in_ask_price  (in_ask_price),
    .in_bid_volume (in_bid_volume),
    .in_ask_volume (in_ask_volume),
    .in_tick_time  (in_tick_time),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_work     (push_work)
  );

  ofi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_work  (push_work),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_work   (pop_work)
  );

  ofi_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_work           (pop_work),
    .window_length      (window_length_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tick_imbalance (out_tick_imbalance),
    .out_window_sum     (out_window_sum),
    .out_entry_count    (out_entry_count),
    .out_primed         (out_primed)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_entry_count <= ofi_pkg::CNT_W'(ofi_pkg::HISTORY_DEPTH)))
    else $error("entry count exceeds ring depth");

  a_prime_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_primed) |-> (out_tick_imbalance == '0))
    else $error("priming word carries a nonzero term");

  a_prime_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_primed && out_tick_imbalance != '0) |-> (out_entry_count != '0)
      || (out_window_sum == '0))
    else $error("primed term reported with an empty ring and nonzero sum");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule
